// ===== design/wdt_pkg.sv =====
// Package for the touch wheel delta tracker: shared types and constants.
`default_nettype none
package wdt_pkg;

	localparam int POS_W   = 6;
	localparam int STATE_W = 16;
	localparam int DELTA_W = 8;

	// Seam detection on the 64-step wheel.
	localparam logic signed [7:0] SEAM_SPAN   = 8'sd32;
	localparam logic signed [7:0] WHEEL_STEPS = 8'sd64;
	localparam logic [POS_W-1:0]  HIGH_ZONE   = 6'd48;
	localparam logic [POS_W-1:0]  LOW_ZONE    = 6'd16;

	// Filter window and rebasing amounts.
	localparam logic signed [STATE_W-1:0] FILT_HIGH   = 16'sd255;
	localparam logic signed [STATE_W-1:0] REBASE_DOWN = 16'sd127;
	localparam logic signed [STATE_W-1:0] REBASE_UP   = 16'sd128;

	localparam logic signed [DELTA_W-1:0] DELTA_MAX = 8'sd127;
	localparam logic signed [DELTA_W-1:0] DELTA_MIN = -8'sd128;

	localparam logic [1:0] INIT_FIRST = 2'd0;
	localparam logic [1:0] INIT_LAST  = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             touched;
	} wdt_sample_t;

	typedef struct packed {
		logic                      valid;
		logic signed [DELTA_W-1:0] delta;
		logic                      touch_seen;
	} wdt_result_t;

endpackage
`default_nettype wire

// ===== design/wdt_track.sv =====
// Tracking state and the combinational unwrap, filter and delta logic.
`default_nettype none
module wdt_track (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire wdt_pkg::wdt_sample_t sample,
	output wdt_pkg::wdt_result_t     result
);
	import wdt_pkg::*;

	logic                needs_init_q;
	logic [1:0]          init_count_q;
	logic [STATE_W-1:0]  unwrapped_q;
	logic [POS_W-1:0]    prev_raw_q;
	logic [STATE_W-1:0]  filtered_q;

	logic                needs_init_d;
	logic [1:0]          init_count_d;
	logic [STATE_W-1:0]  unwrapped_d;
	logic [POS_W-1:0]    prev_raw_d;
	logic [STATE_W-1:0]  filtered_d;

	logic [STATE_W-1:0]      init_sum;
	logic signed [7:0]       d_raw;
	logic signed [7:0]       d_adj;
	logic [STATE_W-1:0]      unw_step;
	logic [STATE_W+1:0]      f_triple;
	logic [STATE_W-1:0]      f_new;
	logic [STATE_W-1:0]      f_reb;
	logic [STATE_W-1:0]      unw_reb;
	logic [STATE_W-1:0]      diff;

	always_comb begin
		needs_init_d = needs_init_q;
		init_count_d = init_count_q;
		unwrapped_d  = unwrapped_q;
		prev_raw_d   = prev_raw_q;
		filtered_d   = filtered_q;
		result       = '0;

		// Initialisation accumulates quarter positions.
		if (init_count_q == INIT_FIRST) begin
			init_sum = {{(STATE_W-4){1'b0}}, sample.position[POS_W-1:2]};
		end else begin
			init_sum = unwrapped_q + {{(STATE_W-4){1'b0}}, sample.position[POS_W-1:2]};
		end

		// Unwrap across the seam between the last and first positions.
		d_raw = $signed({2'b00, sample.position}) - $signed({2'b00, prev_raw_q});
		if (d_raw > SEAM_SPAN && sample.position > HIGH_ZONE && prev_raw_q < LOW_ZONE) begin
			d_adj = d_raw - WHEEL_STEPS;
		end else if (d_raw < -SEAM_SPAN && sample.position < HIGH_ZONE
				&& prev_raw_q > LOW_ZONE) begin
			d_adj = d_raw + WHEEL_STEPS;
		end else begin
			d_adj = d_raw;
		end
		unw_step = unwrapped_q + {{(STATE_W-8){d_adj[7]}}, d_adj};

		// Three quarters of the old filter value plus a quarter of the position.
		f_triple = {{2{filtered_q[STATE_W-1]}}, filtered_q}
			+ {filtered_q[STATE_W-1], filtered_q, 1'b0};
		f_new = f_triple[STATE_W+1:2]
			+ {{2{unw_step[STATE_W-1]}}, unw_step[STATE_W-1:2]};

		f_reb   = f_new;
		unw_reb = unw_step;
		if ($signed(f_reb) >= FILT_HIGH) begin
			f_reb   = f_reb - REBASE_DOWN;
			unw_reb = unw_reb - REBASE_DOWN;
		end
		if ($signed(f_reb) <= 16'sd0) begin
			f_reb   = f_reb + REBASE_UP;
			unw_reb = unw_reb + REBASE_UP;
		end

		// Rebasing moves both values alike, so the raw difference is the motion.
		diff = f_new - filtered_q;

		if (!sample.touched) begin
			needs_init_d = 1'b1;
			init_count_d = INIT_FIRST;
			result.valid = 1'b1;
		end else if (needs_init_q) begin
			unwrapped_d = init_sum;
			if (init_count_q != INIT_LAST) begin
				init_count_d = init_count_q + 2'd1;
			end else begin
				init_count_d      = INIT_FIRST;
				prev_raw_d        = init_sum[POS_W-1:0];
				filtered_d        = init_sum;
				needs_init_d      = 1'b0;
				result.valid      = 1'b1;
				result.touch_seen = 1'b1;
			end
		end else begin
			unwrapped_d       = unw_reb;
			prev_raw_d        = sample.position;
			filtered_d        = f_reb;
			result.valid      = 1'b1;
			result.touch_seen = 1'b1;
			if ($signed(diff) > $signed({{(STATE_W-DELTA_W){1'b0}}, DELTA_MAX})) begin
				result.delta = DELTA_MAX;
			end else if ($signed(diff) < $signed({{(STATE_W-DELTA_W){1'b1}}, DELTA_MIN})) begin
				result.delta = DELTA_MIN;
			end else begin
				result.delta = diff[DELTA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needs_init_q <= 1'b1;
			init_count_q <= INIT_FIRST;
			unwrapped_q  <= '0;
			prev_raw_q   <= '0;
			filtered_q   <= '0;
		end else if (fire) begin
			needs_init_q <= needs_init_d;
			init_count_q <= init_count_d;
			unwrapped_q  <= unwrapped_d;
			prev_raw_q   <= prev_raw_d;
			filtered_q   <= filtered_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/touch_wheel_delta_tracker.sv =====
// Top level of the touch wheel delta tracker: input register, tracker and result register.
`default_nettype none
// Accepts one wheel sample per clock cycle while sample_stall is low and returns its
// result through the input register and then the result register; the tracking state
// is updated as each sample leaves the input register, so consecutive samples do not wait
// on each other. An untouched sample gives delta 0 with touch_seen low and restarts the
// four-sample initialisation; the first three touched samples after that give no result,
// the fourth gives delta 0 with touch_seen high, and every later touched sample gives the
// filtered motion clamped to a signed byte. A stalled result holds the input register
// once it is full.
module touch_wheel_delta_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire logic [wdt_pkg::POS_W-1:0]         position,
	input  wire logic                              touched,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic signed [wdt_pkg::DELTA_W-1:0]     delta,
	output logic                                   touch_seen
);
	import wdt_pkg::*;

	logic                      valid_s1;
	wdt_sample_t               sample_s1;
	logic                      advance;
	logic                      fire;
	wdt_result_t               result;
	logic                      result_valid_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic                      touch_seen_q;

	assign advance      = !result_valid_q || !result_stall;
	assign fire         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1.position <= position;
			sample_s1.touched  <= touched;
		end
	end

	wdt_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.sample (sample_s1),
		.result (result)
	);

	// Samples that only feed initialisation produce no transfer on the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= fire && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			delta_q      <= result.delta;
			touch_seen_q <= result.touch_seen;
		end
	end

	assign result_valid = result_valid_q;
	assign delta        = delta_q;
	assign touch_seen   = touch_seen_q;

endmodule
`default_nettype wire
